/* hw/rtl/serial_drive_command_receiver_core_defines.svh */
// assertion macros for the serial drive command receiver
// used by the top level only; no other dependencies
`ifndef SERIAL_DRIVE_COMMAND_RECEIVER_CORE_DEFINES_SVH
`define SERIAL_DRIVE_COMMAND_RECEIVER_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define SDCR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sdcr same-cycle check failed");

// condition implies consequence in the next cycle
`define SDCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sdcr next-cycle check failed");

`endif

/* hw/rtl/sdcr_pkg.sv */
// shared types and constants for the serial drive command receiver
// no dependencies
`default_nettype none

package sdcr_pkg;

	// input item kinds
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// framing
	localparam logic [7:0]  SYNC_FIRST  = 8'hCD;
	localparam logic [7:0]  SYNC_SECOND = 8'hAB;
	localparam logic [15:0] START_WORD  = 16'hABCD;
	localparam logic [2:0]  POS_SECOND  = 3'd1;
	localparam logic [2:0]  POS_LAST    = 3'd7;
	localparam int          POS_FIRST_STORED = 2;
	localparam int          POS_LAST_STORED  = 6;

	// millisecond counter
	localparam logic [15:0] MS_MAX      = 16'hFFFF;
	localparam logic [15:0] LIMIT_RESET = 16'd500;

	// register map: word index taken from paddr[2]
	localparam int    PADDR_W      = 3;
	localparam logic  REG_TIMEOUT  = 1'b0;

	// drive scaling: (x * 1024) / 60 == (x * 256) / 15
	localparam int DRIVE_SCALE     = 1024;
	localparam int DRIVE_DIV       = 60;
	localparam int SCALE_RED       = DRIVE_SCALE / 4;
	localparam int DIV_RED         = DRIVE_DIV / 4;
	localparam int SCALE_SHIFT     = $clog2(SCALE_RED);
	// 256/15 leaves a fraction step of 17 per unit of remainder
	localparam int FRAC_STEP       = SCALE_RED / DIV_RED;
	// reciprocal of 15, exact for magnitudes below 2^16
	localparam int RECIP_SHIFT     = 19;
	localparam int RECIP           = ((2 ** RECIP_SHIFT) + DIV_RED - 1) / DIV_RED;

	// output tdata layout
	localparam int OUT_ACC_LSB     = 0;
	localparam int OUT_SPEED_LSB   = 1;
	localparam int OUT_STEER_LSB   = 17;
	localparam int OUT_TOUT_LSB    = 33;
	localparam int OUT_LEFT_LSB    = 34;
	localparam int OUT_RIGHT_LSB   = 50;
	localparam int OUT_USED_W      = 66;
	localparam int OUT_TDATA_W     = 72;

	// command status after one item
	typedef struct packed {
		logic        accepted;
		logic [15:0] speed;
		logic [15:0] steer;
		logic        timed_out;
	} cmd_status_t;

endpackage

`default_nettype wire

/* hw/rtl/sdcr_frame.sv */
// frame hunter, checksum check, command latch and link timeout
// depends on sdcr_pkg
`default_nettype none

module sdcr_frame
	import sdcr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        op,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [15:0] limit,
	output cmd_status_t      status_s2
);

	logic        hunting_q, hunting_n;
	logic [2:0]  pos_q, pos_n, wr_idx;
	logic        store;
	logic [7:0]  frame_q [POS_FIRST_STORED:POS_LAST_STORED];
	logic [15:0] speed_q, speed_n;
	logic [15:0] steer_q, steer_n;
	logic        flag_q, flag_n;
	logic [15:0] ms_q, ms_n;
	logic        accept;
	logic [15:0] steer_w, speed_w, sum_w;

	// words of the frame once the last byte arrives
	assign steer_w = {frame_q[3], frame_q[2]};
	assign speed_w = {frame_q[5], frame_q[4]};
	assign sum_w   = {rx_byte, frame_q[6]};

	// next state for one item
	always_comb begin
		hunting_n = hunting_q;
		pos_n     = pos_q;
		wr_idx    = pos_q;
		store     = 1'b0;
		speed_n   = speed_q;
		steer_n   = steer_q;
		flag_n    = flag_q;
		ms_n      = ms_q;
		accept    = 1'b0;
		if (op == OP_TICK) begin
			ms_n = (ms_q == MS_MAX) ? ms_q : ms_q + 16'd1;
			if (ms_n > limit) begin
				flag_n  = 1'b1;
				speed_n = '0;
				steer_n = '0;
			end
		end else begin
			if (hunting_q) begin
				if (rx_byte == SYNC_FIRST) begin
					hunting_n = 1'b0;
					pos_n     = '0;
				end
			end else if (pos_q == POS_SECOND && rx_byte != SYNC_SECOND) begin
				hunting_n = 1'b1;
			end
			if (!hunting_n) begin
				wr_idx = pos_n;
				store  = 1'b1;
				if (pos_n == POS_LAST) begin
					// full frame: checksum against xor of the three words
					if ((START_WORD ^ steer_w ^ speed_w) == sum_w) begin
						ms_n    = '0;
						flag_n  = 1'b0;
						speed_n = speed_w;
						steer_n = steer_w;
						accept  = 1'b1;
					end
					hunting_n = 1'b1;
					pos_n     = '0;
				end else begin
					pos_n = pos_n + 3'd1;
				end
			end
		end
	end

	// control and command state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q <= 1'b1;
			pos_q     <= '0;
			speed_q   <= '0;
			steer_q   <= '0;
			flag_q    <= 1'b0;
			ms_q      <= '0;
		end else if (en) begin
			hunting_q <= hunting_n;
			pos_q     <= pos_n;
			speed_q   <= speed_n;
			steer_q   <= steer_n;
			flag_q    <= flag_n;
			ms_q      <= ms_n;
		end
	end

	// frame byte store; sync bytes and the last byte are never read back
	always_ff @(posedge clk) begin
		if (en && store && wr_idx >= 3'(POS_FIRST_STORED) && wr_idx <= 3'(POS_LAST_STORED)) begin
			frame_q[wr_idx] <= rx_byte;
		end
	end

	// status register toward the drive stage
	always_ff @(posedge clk) begin
		if (en) begin
			status_s2.accepted  <= accept;
			status_s2.speed     <= speed_n;
			status_s2.steer     <= steer_n;
			status_s2.timed_out <= flag_n;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/sdcr_drive.sv */
// left and right drive values from the latched commands, packed for output
// depends on sdcr_pkg
`default_nettype none

module sdcr_drive
	import sdcr_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire cmd_status_t            status_s2,
	output logic [OUT_TDATA_W-1:0]      tdata_s3
);

	// ((x * 1024) / 60) truncated toward zero, wrapped to 16 bits
	function automatic logic [15:0] scale_drive(input logic [16:0] sum);
		logic        neg;
		logic [16:0] nsum;
		logic [15:0] mag_in;
		logic [32:0] prod;
		logic [12:0] quo;
		logic [3:0]  rem;
		logic [19:0] mag;
		logic [19:0] res;
		neg    = sum[16];
		nsum   = -sum;
		mag_in = neg ? nsum[15:0] : sum[15:0];
		prod   = 33'(mag_in) * 33'(RECIP);
		quo    = 13'(prod >> RECIP_SHIFT);
		rem    = 4'(mag_in - 16'(quo * DIV_RED));
		mag    = (20'(quo) << SCALE_SHIFT) + 20'(rem * FRAC_STEP);
		res    = neg ? -mag : mag;
		return res[15:0];
	endfunction

	logic [16:0] steer_adj;
	logic [15:0] half_steer;
	logic [16:0] sum_left, sum_right;

	// steer / 2 rounded toward zero, then the two sums at 17 bits
	assign steer_adj  = {status_s2.steer[15], status_s2.steer} + 17'(status_s2.steer[15]);
	assign half_steer = steer_adj[16:1];
	assign sum_left   = {status_s2.speed[15], status_s2.speed} + {half_steer[15], half_steer};
	assign sum_right  = {status_s2.speed[15], status_s2.speed} - {half_steer[15], half_steer};

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			tdata_s3 <= {(OUT_TDATA_W - OUT_USED_W)'(0),
				scale_drive(sum_right),
				scale_drive(sum_left),
				status_s2.timed_out,
				status_s2.steer,
				status_s2.speed,
				status_s2.accepted};
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/serial_drive_command_receiver_core.sv */
// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready  tdata: rx_byte; tuser: operation
// m_*       out  m_tvalid / m_tready  tdata: frame_accepted .. right_drive
// apb       in   psel/penable/pready  timeout_limit_ms at word 0
//
// one item per cycle sustained while m_tready is high; every item leaves after three register stages
// (input register, command state update, drive scaling) with one result each
// a stalled output holds its register and backs up the stages one at a time
// arst_n clears valid bits, framing state, commands, counter and the limit (500)
// top level: depends on sdcr_pkg, sdcr_frame, sdcr_drive and the defines header
`default_nettype none
`include "serial_drive_command_receiver_core_defines.svh"

module serial_drive_command_receiver_core
	import sdcr_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// input stream
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [7:0]              s_tdata,   // [7:0] rx_byte
	input  wire logic                    s_tuser,   // [0] operation
	// output stream
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	// [0] frame_accepted, [16:1] speed_cmd, [32:17] steer_cmd, [33] timed_out,
	// [49:34] left_drive, [65:50] right_drive, [71:66] zero
	output logic [OUT_TDATA_W-1:0]       m_tdata,
	// configuration
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [PADDR_W-1:0]      paddr,
	input  wire logic [31:0]             pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic        valid_s1, valid_s2;
	logic        op_s1;
	logic [7:0]  byte_s1;
	logic        rdy1, rdy2, rdy3;
	logic [15:0] limit_q;
	logic        cfg_wr;
	cmd_status_t status_s2;

	// stage readiness chain
	assign rdy3     = !m_tvalid || m_tready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign s_tready = rdy1;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT);
	assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'b0, limit_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[15:0];
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= s_tvalid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) m_tvalid <= valid_s2;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (s_tvalid && rdy1) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// command state update on each transfer from stage one
	sdcr_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (valid_s1 && rdy2),
		.op        (op_s1),
		.rx_byte   (byte_s1),
		.limit     (limit_q),
		.status_s2 (status_s2)
	);

	// drive scaling into the output register
	sdcr_drive u_drive (
		.clk       (clk),
		.en        (valid_s2 && rdy3),
		.status_s2 (status_s2),
		.tdata_s3  (m_tdata)
	);

	// checks
	`SDCR_ASSERT_NOW(a_timeout_zeroes, clk, arst_n, m_tvalid && m_tdata[OUT_TOUT_LSB], m_tdata[OUT_TOUT_LSB-1:OUT_SPEED_LSB] == '0)
	`SDCR_ASSERT_NOW(a_accept_clears, clk, arst_n, m_tvalid && m_tdata[OUT_ACC_LSB], !m_tdata[OUT_TOUT_LSB])
	`SDCR_ASSERT_NOW(a_full_rate, clk, arst_n, m_tready, s_tready)
	`SDCR_ASSERT_NEXT(a_stage2_holds, clk, arst_n, valid_s2 && !rdy3, valid_s2)

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// self-checking bench for serial_drive_command_receiver_core: framed byte and tick
// traffic in, every result compared against an in-bench command/drive predictor
// depends on sdcr_pkg and the core rtl only
`default_nettype none

module tb_top;
	import sdcr_pkg::*;

	typedef struct {
		logic        accepted;
		logic [15:0] speed;
		logic [15:0] steer;
		logic        timed_out;
		logic [15:0] left;
		logic [15:0] right;
	} drive_status_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;   // [7:0] rx_byte
	logic                   s_tuser;   // [0] operation
	logic                   m_tvalid;
	logic                   m_tready;
	// [0] frame_accepted, [16:1] speed, [32:17] steer, [33] timed_out,
	// [49:34] left_drive, [65:50] right_drive, [71:66] zero
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [31:0]            pwdata;
	logic [31:0]            prdata;
	logic                   pready;

	// predicted receiver state
	bit          rx_hunting;
	int unsigned rx_pos;
	logic [7:0]  rx_frame [8];
	logic [15:0] cmd_speed;
	logic [15:0] cmd_steer;
	bit          cmd_timeout;
	logic [15:0] ms_count;
	logic [15:0] limit_ms;

	drive_status_t pending_status[$];
	drive_status_t want_status;

	int unsigned items_sent;
	int unsigned results_checked;
	int unsigned frames_taken;
	int unsigned timeout_events;
	int unsigned fail_count;
	int unsigned burst_left;
	bit          gaps_on;
	bit          stall_on;
	logic [7:0]  stall_mask;
	logic [2:0]  stall_phase;

	serial_drive_command_receiver_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// ((speed +/- steer/2) * 1024) / 60, truncating, wrapped to 16 bits
	function automatic logic [15:0] scaled_drive(input logic signed [15:0] spd,
			input logic signed [15:0] str, input bit left_side);
		int s;
		int half;
		int total;
		int q;
		s = spd;
		half = str;
		half = half / 2;
		total = left_side ? s + half : s - half;
		q = (total * 1024) / 60;
		return q[15:0];
	endfunction

	// advance the predicted receiver by one accepted transfer
	function automatic void step_receiver(input logic op, input logic [7:0] b);
		drive_status_t res;
		logic [15:0] w_start;
		logic [15:0] w_steer;
		logic [15:0] w_speed;
		logic [15:0] w_sum;
		bit was_timeout;
		was_timeout = cmd_timeout;
		res.accepted = 1'b0;
		if (op == OP_TICK) begin
			if (ms_count != MS_MAX)
				ms_count = ms_count + 16'd1;
			if (ms_count > limit_ms) begin
				cmd_timeout = 1'b1;
				cmd_speed = '0;
				cmd_steer = '0;
			end
		end else begin
			if (rx_hunting) begin
				if (b == SYNC_FIRST) begin
					rx_hunting = 1'b0;
					rx_pos = 0;
				end
			end else if (rx_pos == 1 && b != SYNC_SECOND) begin
				// bad second sync byte is dropped, not rechecked
				rx_hunting = 1'b1;
			end
			if (!rx_hunting) begin
				rx_frame[rx_pos] = b;
				rx_pos++;
				if (rx_pos == 8) begin
					w_start = {rx_frame[1], rx_frame[0]};
					w_steer = {rx_frame[3], rx_frame[2]};
					w_speed = {rx_frame[5], rx_frame[4]};
					w_sum   = {rx_frame[7], rx_frame[6]};
					if ((w_start ^ w_steer ^ w_speed) == w_sum) begin
						ms_count = '0;
						cmd_timeout = 1'b0;
						cmd_speed = w_speed;
						cmd_steer = w_steer;
						res.accepted = 1'b1;
						frames_taken++;
					end
					rx_hunting = 1'b1;
					rx_pos = 0;
				end
			end
		end
		if (cmd_timeout && !was_timeout)
			timeout_events++;
		res.speed = cmd_speed;
		res.steer = cmd_steer;
		res.timed_out = cmd_timeout;
		res.left = scaled_drive(cmd_speed, cmd_steer, 1'b1);
		res.right = scaled_drive(cmd_speed, cmd_steer, 1'b0);
		pending_status.push_back(res);
	endfunction

	// one input transfer; entered and left at a falling edge
	task automatic send_item(input logic op, input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 5) : 0;
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		step_receiver(op, b);
		items_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [15:0] steer, input logic [15:0] speed,
			input bit spoil);
		logic [15:0] chk;
		chk = START_WORD ^ steer ^ speed;
		if (spoil)
			chk = chk ^ 16'($urandom_range(1, 65535));
		send_item(OP_BYTE, SYNC_FIRST);
		send_item(OP_BYTE, SYNC_SECOND);
		send_item(OP_BYTE, steer[7:0]);
		send_item(OP_BYTE, steer[15:8]);
		send_item(OP_BYTE, speed[7:0]);
		send_item(OP_BYTE, speed[15:8]);
		send_item(OP_BYTE, chk[7:0]);
		send_item(OP_BYTE, chk[15:8]);
	endtask

	task automatic send_ticks(input int unsigned n);
		repeat (n)
			send_item(OP_TICK, 8'($urandom));
	endtask

	// stop sending and let every expected result drain
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_status.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// write the timeout limit, then read it back
	task automatic set_timeout_limit(input logic [15:0] lim);
		paddr <= {REG_TIMEOUT, 2'b00};
		pwdata <= {16'h0000, lim};
		pwrite <= 1'b1;
		psel <= 1'b1;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		limit_ms = lim;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[15:0] !== lim) begin
			$display("%0t: timeout limit readback expected %0d actual %0d",
				$time, lim, prdata[15:0]);
			fail_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic pick_idling();
		gaps_on = $urandom_range(0, 2) != 0;
		stall_on = $urandom_range(0, 2) != 0;
		stall_mask = 8'($urandom_range(1, 255));
	endtask

	function automatic logic [15:0] pick_command();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 3));
			3: return 16'hFFFF - 16'($urandom_range(0, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	// extremes, wrong second sync, bad checksum, a plain tick
	task automatic test_framing_cases();
		gaps_on = 1'b0;
		stall_on = 1'b0;
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_frame(16'h8000, 16'h7FFF, 1'b0);
		send_frame(16'h7FFF, 16'h8000, 1'b0);
		send_item(OP_BYTE, SYNC_FIRST);
		send_item(OP_BYTE, SYNC_FIRST);
		send_item(OP_BYTE, SYNC_SECOND);
		send_frame(16'h0123, 16'hFEDC, 1'b1);
		send_item(OP_TICK, 8'hFF);
		wait_drained();
	endtask

	// timeout at a limit of 1, repeated ticks, recovery by a frame
	task automatic test_link_timeout();
		pick_idling();
		set_timeout_limit(16'd1);
		send_frame(16'hFFFF, 16'h0064, 1'b0);
		send_ticks(3);
		send_frame(16'h0011, 16'h2222, 1'b1);
		send_frame(16'hFF9C, 16'hFC18, 1'b0);
		send_ticks(1);
		wait_drained();
		set_timeout_limit(16'd3);
		send_ticks(5);
		wait_drained();
	endtask

	// tick run under the highest limit never trips, then a lower limit does
	task automatic test_high_limit();
		pick_idling();
		set_timeout_limit(16'hFFFF);
		send_frame(16'h1234, 16'h0400, 1'b0);
		send_ticks(24);
		wait_drained();
		set_timeout_limit(16'd20);
		send_ticks(2);
		wait_drained();
	endtask

	// mostly well-formed frames with random content, ticks and line noise
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned phase;
		int unsigned first_item;
		logic [15:0] lim;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: lim = 16'd1;
				1: lim = 16'($urandom_range(2, 12));
				2: lim = 16'hFFFF;
				3: lim = 16'($urandom_range(13, 60));
				4: lim = LIMIT_RESET;
				default: lim = 16'($urandom_range(1, 65535));
			endcase
			wait_drained();
			set_timeout_limit(lim);
			pick_idling();
			first_item = items_sent;
			while (items_sent - first_item < n_items / 6) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8:
						send_frame(pick_command(), pick_command(), $urandom_range(0, 9) == 0);
					9: begin
						// broken frame: sync then a few random bytes
						send_item(OP_BYTE, SYNC_FIRST);
						repeat ($urandom_range(1, 6))
							send_item(OP_BYTE, 8'($urandom));
					end
					10, 11, 12, 13, 14, 15:
						send_ticks($urandom_range(1, 6));
					default:
						send_item(OP_BYTE, 8'($urandom));
				endcase
				if ($urandom_range(0, 60) == 0)
					wait_drained();
			end
		end
		wait_drained();
	endtask

	// output stall pattern
	always @(negedge clk) begin
		stall_phase <= stall_phase + 3'd1;
		m_tready <= !stall_on || stall_mask[stall_phase];
	end

	task automatic check_field(input string label, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, label, want, got);
			fail_count++;
		end
	endtask

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_status.size() == 0) begin
				$display("%0t: unexpected result expected none actual %h", $time, m_tdata);
				fail_count++;
			end else begin
				want_status = pending_status.pop_front();
				results_checked++;
				check_field("frame_accepted", 16'(want_status.accepted),
					16'(m_tdata[OUT_ACC_LSB]));
				check_field("speed_cmd", want_status.speed, m_tdata[OUT_SPEED_LSB +: 16]);
				check_field("steer_cmd", want_status.steer, m_tdata[OUT_STEER_LSB +: 16]);
				check_field("timed_out", 16'(want_status.timed_out),
					16'(m_tdata[OUT_TOUT_LSB]));
				check_field("left_drive", want_status.left, m_tdata[OUT_LEFT_LSB +: 16]);
				check_field("right_drive", want_status.right, m_tdata[OUT_RIGHT_LSB +: 16]);
				check_field("padding", 16'h0000,
					16'(m_tdata[OUT_TDATA_W-1:OUT_USED_W]));
			end
		end
	end

	// overall time limit
	initial begin
		#12000000;
		$display("[serial_drive_command_receiver_core] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_BYTE;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		gaps_on = 1'b0;
		stall_on = 1'b0;
		stall_mask = 8'hFF;
		stall_phase = '0;
		burst_left = 0;
		items_sent = 0;
		results_checked = 0;
		frames_taken = 0;
		timeout_events = 0;
		fail_count = 0;
		rx_hunting = 1'b1;
		rx_pos = 0;
		cmd_speed = '0;
		cmd_steer = '0;
		cmd_timeout = 1'b0;
		ms_count = '0;
		limit_ms = LIMIT_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_framing_cases();
		test_link_timeout();
		test_high_limit();
		test_random_traffic(640);

		$display("covered %0d transfers in, %0d results checked", items_sent, results_checked);
		$display("%0d frames accepted, %0d link timeouts, limits from 1 to 65535",
			frames_taken, timeout_events);
		if (fail_count == 0)
			$display("[serial_drive_command_receiver_core] OK");
		else
			$display("[serial_drive_command_receiver_core] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
